/* rtl/epfa_pkg.sv */
// ----------------------------------------------------------------------------
// epfa_pkg
// Shared constants, types and register codes of the event polarity frame
// accumulator.
// ----------------------------------------------------------------------------
package epfa_pkg;

    // Image geometry. Columns are addressed by event_y, rows by event_x.
    localparam int IMG_WIDTH  = 128;
    localparam int IMG_HEIGHT = 128;
    localparam int PIX_COUNT  = IMG_WIDTH * IMG_HEIGHT;
    localparam int ADDR_W     = $clog2(PIX_COUNT);

    // Fixed field widths
    localparam int COORD_W = 7;
    localparam int POL_W   = 2;
    localparam int SUM_W   = 16;
    localparam int LEVEL_W = 16;

    // Epoch tag kept with every entry. Tag zero is what a sweep leaves behind.
    localparam int              TAG_W   = 12;
    localparam logic [TAG_W-1:0] TAG_MAX = {TAG_W{1'b1}};
    localparam int              WORD_W  = TAG_W + SUM_W;

    // Configuration register indexes
    localparam int             CFG_IDX_W    = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEGATIVE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITIVE = 2'd2;

    localparam logic [LEVEL_W-1:0] NEGATIVE_RST = 16'd0;
    localparam logic [LEVEL_W-1:0] NEUTRAL_RST  = 16'd125;
    localparam logic [LEVEL_W-1:0] POSITIVE_RST = 16'd255;

    typedef enum logic {
        ST_SWEEP,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [SUM_W-1:0] sum;
    } t_word;

    // Event that updates a pixel, as it enters the update stage
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [POL_W-1:0]   pol;
        logic [TAG_W-1:0]   epoch;
    } t_evt;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_word             data;
    } t_wr;

    typedef struct packed {
        logic [LEVEL_W-1:0] neg;
        logic [LEVEL_W-1:0] neu;
        logic [LEVEL_W-1:0] pos;
    } t_levels;

endpackage

/* rtl/epfa_ram.sv */
// ----------------------------------------------------------------------------
// epfa_ram
// Simple dual-port synchronous RAM, one write and one registered read port,
// read returns the old data on a same-address collision.
// ----------------------------------------------------------------------------
module epfa_ram #(
    parameter int DEPTH = 16384,
    parameter int WIDTH = 28
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/epfa_update.sv */
// ----------------------------------------------------------------------------
// epfa_update
// Read-modify-write stage: forwards the last write, adds polarity with
// saturation, writes back and holds the result in the output register.
// ----------------------------------------------------------------------------
module epfa_update (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_flush,
    input  logic                         i_load,
    input  epfa_pkg::t_evt               i_evt,
    input  epfa_pkg::t_word              i_rdata,
    input  epfa_pkg::t_levels            i_levels,
    output logic                         o_can_take,
    output logic                         o_busy,
    output epfa_pkg::t_wr                o_wr,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [epfa_pkg::COORD_W-1:0] o_col,
    output logic [epfa_pkg::COORD_W-1:0] o_row,
    output logic [epfa_pkg::LEVEL_W-1:0] o_value
);
    import epfa_pkg::*;

    logic               r_s1_valid;
    t_evt               r_s1;
    logic               r_wb_valid;
    logic [ADDR_W-1:0]  r_wb_addr;
    t_word              r_wb_data;
    logic               r_out_valid;
    logic [COORD_W-1:0] r_out_col;
    logic [COORD_W-1:0] r_out_row;
    logic [LEVEL_W-1:0] r_out_value;

    logic               s1_fire;
    t_word              cur;
    logic [SUM_W-1:0]   old_sum;
    logic [SUM_W:0]     add;
    logic [SUM_W-1:0]   sat;
    logic [LEVEL_W-1:0] level;

    assign s1_fire    = r_s1_valid && (!r_out_valid || i_ready);
    assign o_can_take = !r_s1_valid || s1_fire;
    assign o_busy     = r_s1_valid;

    always_comb begin
        // the write issued at the same edge as our read is not in the RAM data
        cur     = (r_wb_valid && (r_wb_addr == r_s1.addr)) ? r_wb_data : i_rdata;
        old_sum = (cur.tag == r_s1.epoch) ? cur.sum : '0;
        add     = {old_sum[SUM_W-1], old_sum}
                + {{(SUM_W+1-POL_W){r_s1.pol[POL_W-1]}}, r_s1.pol};
        if (add[SUM_W] != add[SUM_W-1]) begin
            sat = add[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sat = add[SUM_W-1:0];
        end
        if (sat[SUM_W-1]) begin
            level = i_levels.neg;
        end else if (sat == '0) begin
            level = i_levels.neu;
        end else begin
            level = i_levels.pos;
        end
        o_wr.en       = s1_fire;
        o_wr.addr     = r_s1.addr;
        o_wr.data.tag = r_s1.epoch;
        o_wr.data.sum = sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_wb_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (i_flush) begin
                r_wb_valid <= 1'b0;
            end else if (s1_fire) begin
                r_wb_valid <= 1'b1;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1 <= i_evt;
        end
        if (s1_fire) begin
            r_wb_addr   <= r_s1.addr;
            r_wb_data   <= o_wr.data;
            r_out_col   <= r_s1.col;
            r_out_row   <= r_s1.row;
            r_out_value <= level;
        end
    end

    assign o_valid = r_out_valid;
    assign o_col   = r_out_col;
    assign o_row   = r_out_row;
    assign o_value = r_out_value;

endmodule

/* rtl/event_polarity_frame_accumulator.sv */
// ----------------------------------------------------------------------------
// event_polarity_frame_accumulator
// Per-pixel signed polarity accumulation of camera events, cleared per packet
// through epoch tags, reporting a level by the sign of the updated sum.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_axis    in         tdata: event_x, event_y, polarity; tuser: new_packet,
//                       coords_valid
//  m_axis    out        tdata: pixel_col, pixel_row, pixel_value
//  cfg       in         i_cfg_we / i_cfg_idx / i_cfg_wdata, level registers
//
//  One event per cycle while no sweep runs and the output is not stalled; a
//  result is registered in the update stage and then in the output register.
//  Throughput is set by the single read-modify-write pass over the pixel RAM,
//  with the last write forwarded to the next read.
//  After reset a sweep zeroes all 16384 RAM entries, taking no input meanwhile.
//  The same sweep runs when the 12-bit epoch tag would wrap: on a new packet
//  while the tag is at 4095. Output stalls propagate back through the two stages.
// ----------------------------------------------------------------------------
module event_polarity_frame_accumulator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [6:0] event_x, [13:7] event_y, [15:14] polarity
    input  logic [15:0]                    s_axis_tdata,
    // [0] new_packet, [1] coords_valid
    input  logic [1:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [6:0] pixel_col, [13:7] pixel_row, [29:14] pixel_value, [31:30] zero
    output logic [31:0]                    m_axis_tdata,
    input  logic                           i_cfg_we,
    input  logic [epfa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [epfa_pkg::LEVEL_W-1:0]   i_cfg_wdata
);
    import epfa_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [ADDR_W-1:0]  r_sweep_addr;
    logic [ADDR_W-1:0]  n_sweep_addr;
    logic [TAG_W-1:0]   r_epoch;
    logic [TAG_W-1:0]   n_epoch;
    t_levels            r_levels;

    logic               new_packet;
    logic               coords_valid;
    logic [COORD_W-1:0] event_x;
    logic [COORD_W-1:0] event_y;
    logic [POL_W-1:0]   polarity;
    logic               in_fire;
    logic               hit;
    logic               wrap_hold;
    logic               sweep_last;
    logic               sweep_start;
    logic               upd_can_take;
    logic               upd_busy;
    t_evt               evt;
    t_wr                upd_wr;
    t_word              rdata;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    t_word              ram_wdata;
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic [LEVEL_W-1:0] out_value;

    assign new_packet   = s_axis_tuser[0];
    assign coords_valid = s_axis_tuser[1];
    assign event_x      = s_axis_tdata[6:0];
    assign event_y      = s_axis_tdata[13:7];
    assign polarity     = s_axis_tdata[15:14];

    assign wrap_hold   = s_axis_tvalid && new_packet && (r_epoch == TAG_MAX);
    assign sweep_last  = (r_sweep_addr == ADDR_W'(PIX_COUNT - 1));
    assign sweep_start = (r_state == ST_RUN) && wrap_hold && !upd_busy;

    assign s_axis_tready = (r_state == ST_RUN) && !wrap_hold && upd_can_take;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign hit = coords_valid
              && (32'(event_y) < IMG_WIDTH)
              && (32'(event_x) < IMG_HEIGHT);

    always_comb begin
        n_epoch = r_epoch;
        if (in_fire && new_packet) begin
            n_epoch = r_epoch + 1'b1;
        end
        evt.addr  = ADDR_W'(32'(event_y) * IMG_HEIGHT + 32'(event_x));
        evt.col   = event_y;
        evt.row   = event_x;
        evt.pol   = polarity;
        evt.epoch = n_epoch;
    end

    // sweep control
    always_comb begin
        n_state      = r_state;
        n_sweep_addr = r_sweep_addr;
        case (r_state)
            ST_SWEEP: begin
                n_sweep_addr = r_sweep_addr + 1'b1;
                if (sweep_last) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (sweep_start) begin
                    n_state      = ST_SWEEP;
                    n_sweep_addr = '0;
                end
            end
            default: begin
                n_state = ST_SWEEP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SWEEP;
            r_sweep_addr <= '0;
            r_epoch      <= '0;
        end else begin
            r_state      <= n_state;
            r_sweep_addr <= n_sweep_addr;
            if (r_state == ST_SWEEP) begin
                r_epoch <= '0;
            end else begin
                r_epoch <= n_epoch;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels.neg <= NEGATIVE_RST;
            r_levels.neu <= NEUTRAL_RST;
            r_levels.pos <= POSITIVE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NEGATIVE: r_levels.neg <= i_cfg_wdata;
                CFG_NEUTRAL:  r_levels.neu <= i_cfg_wdata;
                CFG_POSITIVE: r_levels.pos <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // sweep owns the write port; the update stage is empty meanwhile
    always_comb begin
        if (r_state == ST_SWEEP) begin
            ram_we    = 1'b1;
            ram_waddr = r_sweep_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = upd_wr.en;
            ram_waddr = upd_wr.addr;
            ram_wdata = upd_wr.data;
        end
    end

    epfa_ram #(
        .DEPTH (PIX_COUNT),
        .WIDTH (WORD_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_fire && hit),
        .i_raddr (evt.addr),
        .o_rdata (rdata)
    );

    epfa_update u_update (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_flush    (r_state == ST_SWEEP),
        .i_load     (in_fire && hit),
        .i_evt      (evt),
        .i_rdata    (rdata),
        .i_levels   (r_levels),
        .o_can_take (upd_can_take),
        .o_busy     (upd_busy),
        .o_wr       (upd_wr),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_col      (out_col),
        .o_row      (out_row),
        .o_value    (out_value)
    );

    assign m_axis_tdata = {2'b00, out_value, out_row, out_col};

`ifndef ASSERT_OFF
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> !in_fire)
        else $error("transaction accepted during sweep");

    a_no_update_write_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> !upd_wr.en)
        else $error("update write collides with sweep");

    a_epoch_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && new_packet) |-> (r_epoch != TAG_MAX))
        else $error("epoch tag wrapped");

    a_sweep_ends_epoch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP && sweep_last) |=> (r_state == ST_RUN && r_epoch == '0))
        else $error("sweep did not end at epoch zero");

    a_sweep_needs_idle_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sweep_start |-> !upd_busy)
        else $error("sweep started with update pending");
`endif

endmodule

/* sim/event_polarity_frame_accumulator_tb.sv */
// ----------------------------------------------------------------------------
// event_polarity_frame_accumulator_tb
// Drives camera events into the accumulator and checks every pixel update
// against a per-pixel polarity sum kept in the bench. The run covers level
// registers, polarity codes, packet clears and random traffic with random
// gaps and output stalls.
// ----------------------------------------------------------------------------
module event_polarity_frame_accumulator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import epfa_pkg::*;

    localparam int           CYCLE_LIMIT = 2_000_000;
    localparam int           DRAIN_LIMIT = 50_000;
    localparam int           MAX_REPORTS = 50;
    localparam int           SETTLE      = 8;
    localparam int           SUM_HI      = 32767;
    localparam int           SUM_LO      = -32768;
    // index past the last level register; a write there must change nothing
    localparam logic [1:0]   CFG_UNUSED  = 2'd3;
    localparam logic [1:0]   POL_ZERO    = 2'b00;
    localparam logic [1:0]   POL_PLUS    = 2'b01;
    localparam logic [1:0]   POL_MINUS2  = 2'b10;
    localparam logic [1:0]   POL_MINUS   = 2'b11;

    typedef struct packed {
        logic [6:0]  col;
        logic [6:0]  row;
        logic [15:0] value;
    } t_pixel_update;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_idx     = '0;
    logic [15:0] i_cfg_wdata   = '0;

    event_polarity_frame_accumulator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Accumulator image kept by the bench. An entry only counts while its
    // packet number matches the current one, so a packet clear is O(1).
    shortint       pixel_sum [PIX_COUNT];
    int            pixel_packet [PIX_COUNT];
    int            packet_no;
    logic [15:0]   lvl_negative = NEGATIVE_RST;
    logic [15:0]   lvl_neutral  = NEUTRAL_RST;
    logic [15:0]   lvl_positive = POSITIVE_RST;
    t_pixel_update pending_updates [$];

    int err_count;
    int cycle_count;
    int gap_pct;
    int stall_pct;
    bit long_idle;
    int stall_left;
    bit          out_take;
    logic [31:0] out_word;

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
                     want);
    endtask

    function automatic void accumulate_event(input logic np, input logic cv,
                                             input logic [6:0] ex, input logic [6:0] ey,
                                             input logic [1:0] pol);
        int            idx;
        int            acc;
        t_pixel_update upd;
        if (np)
            packet_no++;
        if (!cv)
            return;
        // 7-bit coordinates always land inside the 128x128 image
        idx = int'(ey) * IMG_HEIGHT + int'(ex);
        acc = (pixel_packet[idx] == packet_no) ? int'(pixel_sum[idx]) : 0;
        acc += int'($signed(pol));
        if (acc > SUM_HI)
            acc = SUM_HI;
        if (acc < SUM_LO)
            acc = SUM_LO;
        pixel_sum[idx]    = shortint'(acc);
        pixel_packet[idx] = packet_no;
        upd.col = ey;
        upd.row = ex;
        if (acc < 0)
            upd.value = lvl_negative;
        else if (acc > 0)
            upd.value = lvl_positive;
        else
            upd.value = lvl_neutral;
        pending_updates.push_back(upd);
    endfunction

    function automatic void set_pace(input int gaps, input int stalls, input bit long_ok);
        gap_pct   = gaps;
        stall_pct = stalls;
        long_idle = long_ok;
    endfunction

    function automatic int pick_idle(input int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if (long_idle && $urandom_range(9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // Called and returning at a rising edge; the event is taken at the
    // edge just before return.
    task automatic send_event(input logic np, input logic cv, input logic [6:0] ex,
                              input logic [6:0] ey, input logic [1:0] pol);
        int gap;
        gap = pick_idle(gap_pct);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) begin
                s_axis_tdata <= 16'($urandom);
                s_axis_tuser <= 2'($urandom);
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pol, ey, ex};
        s_axis_tuser  <= {cv, np};
        // tready seen at the falling edge holds through the next rising edge
        do
            @(negedge i_clk);
        while (s_axis_tready !== 1'b1);
        accumulate_event(np, cv, ex, ey, pol);
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_updates.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_NEGATIVE: lvl_negative = value;
            CFG_NEUTRAL:  lvl_neutral  = value;
            CFG_POSITIVE: lvl_positive = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_levels(input logic [15:0] neg, input logic [15:0] neu,
                              input logic [15:0] pos);
        wait_idle();
        cfg_write(CFG_NEGATIVE, neg);
        cfg_write(CFG_NEUTRAL, neu);
        cfg_write(CFG_POSITIVE, pos);
    endtask

    task automatic send_repeat(input int count, input logic [6:0] ex, input logic [6:0] ey,
                               input logic [1:0] pol);
        repeat (count) send_event(1'b0, 1'b1, ex, ey, pol);
    endtask

    // Reset levels, all four polarity codes, corner pixels, clear on an
    // event without coordinates, back-to-back hits on one pixel.
    task automatic test_directed();
        set_pace(0, 0, 1'b0);
        send_event(1'b1, 1'b1, 7'd0,    7'd0,    POL_PLUS);
        send_event(1'b0, 1'b1, 7'd127,  7'd127,  POL_MINUS);
        send_event(1'b0, 1'b1, 7'd127,  7'd0,    POL_ZERO);
        send_event(1'b0, 1'b1, 7'd0,    7'd127,  POL_MINUS2);
        send_event(1'b0, 1'b1, 7'h55,   7'h2a,   POL_PLUS);
        send_event(1'b0, 1'b1, 7'h2a,   7'h55,   POL_MINUS);
        send_event(1'b0, 1'b1, 7'd0,    7'd0,    POL_MINUS);
        send_event(1'b0, 1'b0, 7'd0,    7'd0,    POL_PLUS);
        send_event(1'b0, 1'b1, 7'd0,    7'd0,    POL_ZERO);
        // clear carried by an event with no coordinates
        send_event(1'b1, 1'b0, 7'd127,  7'd127,  POL_MINUS2);
        send_event(1'b0, 1'b1, 7'd127,  7'd127,  POL_ZERO);
        send_event(1'b0, 1'b1, 7'd0,    7'd127,  POL_PLUS);
        // read-modify-write on one pixel every cycle
        send_repeat(3, 7'd3, 7'd4, POL_PLUS);
        send_repeat(2, 7'd3, 7'd4, POL_MINUS2);
        send_event(1'b0, 1'b1, 7'd3,    7'd4,    POL_PLUS);
        send_event(1'b1, 1'b1, 7'd3,    7'd4,    POL_MINUS);
        send_event(1'b0, 1'b1, 7'd3,    7'd4,    POL_PLUS);
        set_pace(50, 50, 1'b0);
        send_repeat(3, 7'd3, 7'd4, POL_MINUS2);
    endtask

    task automatic test_levels();
        set_levels(16'hffff, 16'h0000, 16'h8000);
        send_event(1'b1, 1'b1, 7'd9, 7'd9, POL_PLUS);
        send_event(1'b0, 1'b1, 7'd9, 7'd9, POL_MINUS);
        send_event(1'b0, 1'b1, 7'd9, 7'd9, POL_MINUS);
        set_levels(16'h0000, 16'hffff, 16'h0001);
        send_event(1'b0, 1'b1, 7'd9, 7'd9, POL_PLUS);
        send_event(1'b0, 1'b1, 7'd9, 7'd9, POL_PLUS);
        send_event(1'b0, 1'b1, 7'd8, 7'd9, POL_MINUS2);
        wait_idle();
        cfg_write(CFG_UNUSED, 16'($urandom));
        send_event(1'b0, 1'b1, 7'd8, 7'd9, POL_ZERO);
        send_event(1'b0, 1'b1, 7'd8, 7'd9, POL_PLUS);
        send_event(1'b0, 1'b1, 7'd8, 7'd9, POL_PLUS);
        set_levels(16'h1234, 16'h00ff, 16'hfedc);
        send_event(1'b0, 1'b1, 7'd8, 7'd9, POL_PLUS);
        send_event(1'b0, 1'b1, 7'd8, 7'd9, POL_MINUS2);
        send_event(1'b0, 1'b1, 7'd8, 7'd9, POL_MINUS);
    endtask

    // Many short packets on a few pixels, with entries left untouched
    // across packets.
    task automatic test_packet_epochs();
        int         k;
        logic [6:0] ex;
        logic [6:0] ey;
        set_pace(0, 10, 1'b0);
        set_levels(16'h0a0a, 16'h5555, 16'hc3c3);
        repeat (180) begin
            k  = $urandom_range(0, 5);
            ex = 7'(10 + k);
            ey = 7'(20 + 3 * k);
            send_event(1'b1, 1'($urandom_range(9) != 0), ex, ey, 2'($urandom));
            repeat ($urandom_range(0, 2)) begin
                k  = $urandom_range(0, 5);
                ex = 7'(10 + k);
                ey = 7'(20 + 3 * k);
                send_event(1'b0, 1'b1, ex, ey, 2'($urandom));
            end
        end
    endtask

    task automatic test_random_traffic();
        logic [6:0] base_x;
        logic [6:0] base_y;
        logic [6:0] ex;
        logic [6:0] ey;
        for (int phase = 0; phase < 8; phase++) begin
            set_levels(16'($urandom), 16'($urandom), 16'($urandom));
            case (phase % 3)
                0: set_pace(30, 30, 1'b1);
                1: set_pace(0, 0, 1'b0);
                default: set_pace(60, 50, 1'b1);
            endcase
            base_x = 7'($urandom);
            base_y = 7'($urandom);
            repeat (100) begin
                // mostly a small window so sums grow past +-1
                if ($urandom_range(9) < 7) begin
                    ex = base_x + 7'($urandom_range(0, 7));
                    ey = base_y + 7'($urandom_range(0, 7));
                end else begin
                    ex = 7'($urandom);
                    ey = 7'($urandom);
                end
                send_event(1'($urandom_range(99) < 3), 1'($urandom_range(99) < 88), ex, ey,
                           2'($urandom));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            stall_left = pick_idle(stall_pct);
            m_axis_tready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    always @(negedge i_clk) begin
        out_take <= (m_axis_tvalid === 1'b1) && m_axis_tready && i_rst_n;
        out_word <= m_axis_tdata;
    end

    always @(posedge i_clk) begin : check_results
        t_pixel_update want;
        if (out_take) begin
            if (pending_updates.size() == 0) begin
                report_mismatch("unexpected transaction", out_word, 0);
            end else begin
                want = pending_updates[0];
                pending_updates.delete(0);
                if (out_word[6:0] !== want.col)
                    report_mismatch("pixel_col", out_word[6:0], want.col);
                if (out_word[13:7] !== want.row)
                    report_mismatch("pixel_row", out_word[13:7], want.row);
                if (out_word[29:14] !== want.value)
                    report_mismatch("pixel_value", out_word[29:14], want.value);
                if (out_word[31:30] !== 2'b00)
                    report_mismatch("tdata pad", out_word[31:30], 0);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("event_polarity_frame_accumulator_tb NOT OK");
            $finish;
        end
    end

    initial begin
        int waited;
        set_pace(0, 0, 1'b0);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_levels();
        test_packet_epochs();
        test_random_traffic();

        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (pending_updates.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE) @(posedge i_clk);
        if (pending_updates.size() != 0)
            report_mismatch("updates never delivered", 0, pending_updates.size());

        if (err_count == 0)
            $display("event_polarity_frame_accumulator_tb OK");
        else
            $display("event_polarity_frame_accumulator_tb NOT OK");
        $finish;
    end

endmodule
